### rtl/core/esd_pkg.sv
// ----------------------------------------------------------------------------
// esd_pkg
// Shared types, widths and tables of the epoch seconds to date converter.
// ----------------------------------------------------------------------------
package esd_pkg;

	localparam int SEC_W    = 38;
	localparam int DAYS_W   = 22;
	localparam int DIFF_W   = DAYS_W + 1;
	localparam int DAY_W    = 5;
	localparam int MONTH_W  = 4;
	localparam int YEAR_W   = 14;

	localparam int LAST_YEAR_DEF = 9999;

	localparam logic [DAYS_W-1:0]  SECS_PER_DAY = DAYS_W'(86400);
	localparam logic [YEAR_W-1:0]  FIRST_YEAR   = YEAR_W'(1970);
	localparam logic [DAYS_W-1:0]  LEAP_LEN     = DAYS_W'(366);
	localparam logic [DAYS_W-1:0]  NORM_LEN     = DAYS_W'(365);
	localparam logic [MONTH_W-1:0] MONTH_DEC    = MONTH_W'(11);
	localparam logic [MONTH_W-1:0] MONTH_FEB    = MONTH_W'(1);

	// 86400 = 675 << 7: days = ((seconds >> 7) * ceil(2^41 / 675)) >> 41,
	// exact for every 31-bit shifted count
	localparam int QUO_SHIFT   = 7;
	localparam int QUO_W       = SEC_W - QUO_SHIFT;
	localparam int RECIP_W     = 32;
	localparam int RECIP_SHIFT = 41;
	localparam int PROD_W      = QUO_W + RECIP_W;
	localparam logic [RECIP_W-1:0] DAY_RECIP = 32'd3257812231;

	// 1970 taken modulo 4, 100 and 400
	localparam logic [1:0] FIRST_M4   = 2'd2;
	localparam logic [6:0] FIRST_M100 = 7'd70;
	localparam logic [8:0] FIRST_M400 = 9'd370;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_YEAR,
		ST_MONTH,
		ST_FIN
	} state_t;

	typedef enum logic {
		OP_YEAR,
		OP_MONTH
	} oper_t;

	typedef struct packed {
		logic [DIFF_W-1:0] diff;
		logic              ge;
	} sub_res_t;

	// month index 0..11, zero based
	function automatic logic [DAYS_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [4:0] len;
		begin
			unique case (m)
				4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
				4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
				4'd1:                                      len = leap ? 5'd29 : 5'd28;
				default:                                   len = 5'd31;
			endcase
			month_len = DAYS_W'(len);
		end
	endfunction

endpackage

### rtl/core/esd_cmpsub.sv
// ----------------------------------------------------------------------------
// esd_cmpsub
// Shared compare-subtract unit: remaining days minus year or month length.
// ----------------------------------------------------------------------------
module esd_cmpsub (
	input  esd_pkg::oper_t                 op,
	input  logic [esd_pkg::DAYS_W-1:0]     days,
	input  logic                           leap,
	input  logic [esd_pkg::MONTH_W-1:0]    month,
	output esd_pkg::sub_res_t              res
);

	logic [esd_pkg::DAYS_W-1:0] b;

	always_comb begin
		unique case (op)
			esd_pkg::OP_YEAR:  b = leap ? esd_pkg::LEAP_LEN : esd_pkg::NORM_LEN;
			esd_pkg::OP_MONTH: b = esd_pkg::month_len(month, leap);
			default:           b = esd_pkg::NORM_LEN;
		endcase
	end

	assign res.diff = {1'b0, days} - {1'b0, b};
	assign res.ge   = ~res.diff[esd_pkg::DIFF_W-1];

endmodule

### rtl/core/epoch_seconds_to_date.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_date
// Converts seconds since 1970-01-01 into day, month and year.
// ----------------------------------------------------------------------------
//  channel | signals                                  | dir
//  --------+------------------------------------------+-----
//  input   | in_valid, in_stall, seconds              | in
//  output  | out_valid, out_stall, day, month, year,  | out
//          | range_error                              |
//
// One beat at a time: 1 accept + 1 reciprocal multiply for whole days + one
// step per year past 1970 plus the closing compare (up to 8031) + up to 12
// month steps + 1 store; a new beat is accepted only after the store.
// Year and month steps run through one shared compare-subtract unit.
// in_stall is high from accept until the result is stored in the output
// register; a stalled result holds the block in its final step.
// arst_n clears the sequencer and the output valid.
module epoch_seconds_to_date #(
	parameter int LAST_YEAR = esd_pkg::LAST_YEAR_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [esd_pkg::SEC_W-1:0]     seconds,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [esd_pkg::DAY_W-1:0]     day,
	output logic [esd_pkg::MONTH_W-1:0]   month,
	output logic [esd_pkg::YEAR_W-1:0]    year,
	output logic                          range_error
);

	localparam logic [esd_pkg::YEAR_W-1:0] LAST_YEAR_W = esd_pkg::YEAR_W'(LAST_YEAR);

	esd_pkg::state_t state_q, state_nxt;
	esd_pkg::oper_t  op;
	esd_pkg::sub_res_t sub;

	logic [esd_pkg::QUO_W-1:0]   sec_q;
	logic [esd_pkg::PROD_W-1:0]  day_prod;
	logic [esd_pkg::DAYS_W-1:0]  days_q;
	logic [esd_pkg::YEAR_W-1:0]  year_q;
	logic [esd_pkg::MONTH_W-1:0] month_q;
	logic [1:0]                  m4_q;
	logic [6:0]                  m100_q;
	logic [8:0]                  m400_q;
	logic                        range_q;
	logic                        leap;
	logic                        past_last;
	logic                        accept;
	logic                        load_out;
	logic                        out_valid_q;
	logic [esd_pkg::DAY_W-1:0]   day_q;
	logic [esd_pkg::MONTH_W-1:0] month_out_q;
	logic [esd_pkg::YEAR_W-1:0]  year_out_q;
	logic                        range_out_q;

	assign leap      = ((m4_q == 2'd0) && (m100_q != 7'd0)) || (m400_q == 9'd0);
	assign past_last = year_q > LAST_YEAR_W;
	assign day_prod  = esd_pkg::PROD_W'(sec_q) * esd_pkg::PROD_W'(esd_pkg::DAY_RECIP);

	esd_cmpsub u_cmpsub (
		.op       (op),
		.days     (days_q),
		.leap     (leap),
		.month    (month_q),
		.res      (sub)
	);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			esd_pkg::ST_IDLE:  if (in_valid) state_nxt = esd_pkg::ST_DIV;
			esd_pkg::ST_DIV:   state_nxt = esd_pkg::ST_YEAR;
			esd_pkg::ST_YEAR: begin
				if (past_last)
					state_nxt = esd_pkg::ST_FIN;
				else if (!sub.ge)
					state_nxt = esd_pkg::ST_MONTH;
			end
			esd_pkg::ST_MONTH: begin
				if (month_q == esd_pkg::MONTH_DEC || !sub.ge)
					state_nxt = esd_pkg::ST_FIN;
			end
			esd_pkg::ST_FIN:   if (!out_valid_q || !out_stall) state_nxt = esd_pkg::ST_IDLE;
			default:           state_nxt = esd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		load_out = 1'b0;
		op       = esd_pkg::OP_YEAR;
		unique case (state_q)
			esd_pkg::ST_IDLE:  in_stall = 1'b0;
			esd_pkg::ST_DIV:   op = esd_pkg::OP_YEAR;
			esd_pkg::ST_YEAR:  op = esd_pkg::OP_YEAR;
			esd_pkg::ST_MONTH: op = esd_pkg::OP_MONTH;
			esd_pkg::ST_FIN:   load_out = !out_valid_q || !out_stall;
			default:           in_stall = 1'b1;
		endcase
	end

	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= esd_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			out_valid_q <= load_out || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sec_q   <= seconds[esd_pkg::SEC_W-1:esd_pkg::QUO_SHIFT];
			year_q  <= esd_pkg::FIRST_YEAR;
			month_q <= '0;
			m4_q    <= esd_pkg::FIRST_M4;
			m100_q  <= esd_pkg::FIRST_M100;
			m400_q  <= esd_pkg::FIRST_M400;
			range_q <= 1'b0;
		end
		unique case (state_q)
			esd_pkg::ST_DIV: begin
				days_q <= day_prod[esd_pkg::RECIP_SHIFT +: esd_pkg::DAYS_W];
			end
			esd_pkg::ST_YEAR: begin
				if (past_last) begin
					range_q <= 1'b1;
				end else if (sub.ge) begin
					days_q <= sub.diff[esd_pkg::DAYS_W-1:0];
					year_q <= year_q + 1'b1;
					m4_q   <= m4_q + 1'b1;
					m100_q <= (m100_q == 7'd99) ? 7'd0 : m100_q + 1'b1;
					m400_q <= (m400_q == 9'd399) ? 9'd0 : m400_q + 1'b1;
				end
			end
			esd_pkg::ST_MONTH: begin
				if (month_q != esd_pkg::MONTH_DEC && sub.ge) begin
					days_q  <= sub.diff[esd_pkg::DAYS_W-1:0];
					month_q <= month_q + 1'b1;
				end
			end
			default: ;
		endcase
		if (load_out) begin
			if (range_q) begin
				day_q       <= esd_pkg::DAY_W'(31);
				month_out_q <= esd_pkg::MONTH_W'(12);
				year_out_q  <= LAST_YEAR_W;
			end else begin
				day_q       <= days_q[esd_pkg::DAY_W-1:0] + 1'b1;
				month_out_q <= month_q + 1'b1;
				year_out_q  <= year_q;
			end
			range_out_q <= range_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign day         = day_q;
	assign month       = month_out_q;
	assign year        = year_out_q;
	assign range_error = range_out_q;

endmodule

### rtl/core/esd_checker.sv
// ----------------------------------------------------------------------------
// esd_checker
// Port-level checks of the epoch seconds to date converter.
// ----------------------------------------------------------------------------
module esd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic [esd_pkg::SEC_W-1:0]     seconds,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [esd_pkg::DAY_W-1:0]     day,
	input logic [esd_pkg::MONTH_W-1:0]   month,
	input logic [esd_pkg::YEAR_W-1:0]    year,
	input logic                          range_error
);

	// busy after taking a beat
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("accepted a second beat while busy");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(year) && $stable(day))
		else $error("stalled result dropped or changed");

	a_date_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !range_error |-> day >= 5'd1 && month >= 4'd1 && month <= 4'd12
			&& year >= esd_pkg::FIRST_YEAR)
		else $error("illegal date on output");

	a_saturate: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_error |-> day == 5'd31 && month == 4'd12)
		else $error("range error without saturated date");

	a_seconds_unused: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && seconds == '0 |=> in_stall)
		else $error("zero input not taken up");

endmodule

bind epoch_seconds_to_date esd_checker u_esd_checker (.*);
